// ===== hw/rtl/rptd_pkg.sv =====
// ----------------------------------------------------------------------------
// rptd_pkg
// Shared constants, command and status types, and the planar-to-pixel
// function of the run-length tile decoder.
// ----------------------------------------------------------------------------
package rptd_pkg;

	localparam int TILE_BYTES  = 16;
	localparam int PLANE_BYTES = TILE_BYTES / 2;
	localparam int ROW_PIXELS  = 8;
	localparam int FILL_W      = $clog2(TILE_BYTES);
	localparam int SEG_W       = FILL_W + 1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic set_marker;  // latch the incoming byte as escape marker
		logic push_lit;    // append the incoming byte as a literal
		logic load_count;  // latch the incoming byte as run count
		logic load_value;  // latch the incoming byte as run value
		logic run_step;    // append one segment of the pending run
		logic end_stream;  // report stream end, drop partial tile
	} rptd_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic is_marker;   // incoming byte equals the escape marker
		logic byte_zero;   // incoming byte is zero
		logic run_last;    // this run segment finishes the run
		logic out_free;    // result register can take a beat this cycle
	} rptd_stat_t;

	// Interleave plane 0 (low bit) and plane 1 (high bit); pixel (x,y) lands
	// at bits 2*(8*y+x), so rows 0-3 fill the low half and rows 4-7 the high.
	function automatic logic [2*TILE_BYTES*ROW_PIXELS/2-1:0] tile_pixels(
		input logic [7:0] b [TILE_BYTES]
	);
		logic [2*TILE_BYTES*ROW_PIXELS/2-1:0] p;
		p = '0;
		for (int y = 0; y < PLANE_BYTES; y++) begin
			for (int x = 0; x < ROW_PIXELS; x++) begin
				p[2*(ROW_PIXELS*y+x)]     = b[y][7-x];
				p[2*(ROW_PIXELS*y+x) + 1] = b[PLANE_BYTES+y][7-x];
			end
		end
		return p;
	endfunction

endpackage

// ===== hw/rtl/rptd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rptd_ctrl
// Decode-phase state machine: steps through marker, data, count and value
// bytes; expands runs one tile segment per cycle while out_free is set.
// ----------------------------------------------------------------------------
module rptd_ctrl
	import rptd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  rptd_stat_t stat,
	output rptd_cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_MARKER = 5'b00001,
		ST_DATA   = 5'b00010,
		ST_COUNT  = 5'b00100,
		ST_VALUE  = 5'b01000,
		ST_RUN    = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   in_acc;

	// Take a byte whenever not expanding a run and the result register is free
	assign in_stall = !((state_q inside {ST_MARKER, ST_DATA, ST_COUNT, ST_VALUE})
		&& stat.out_free);
	assign in_acc   = in_valid && !in_stall;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_MARKER: begin
				if (in_acc) begin
					cmd.set_marker = 1'b1;
					state_d        = ST_DATA;
				end
			end
			ST_DATA: begin
				if (in_acc) begin
					if (stat.is_marker) begin
						state_d = ST_COUNT;
					end else begin
						cmd.push_lit = 1'b1;
					end
				end
			end
			ST_COUNT: begin
				if (in_acc) begin
					if (stat.byte_zero) begin
						cmd.end_stream = 1'b1;
						state_d        = ST_MARKER;
					end else begin
						cmd.load_count = 1'b1;
						state_d        = ST_VALUE;
					end
				end
			end
			ST_VALUE: begin
				if (in_acc) begin
					cmd.load_value = 1'b1;
					state_d        = ST_RUN;
				end
			end
			ST_RUN: begin
				if (stat.out_free) begin
					cmd.run_step = 1'b1;
					if (stat.run_last) begin
						state_d = ST_DATA;
					end
				end
			end
			default: begin
				state_d = ST_MARKER;
			end
		endcase
	end

	// Hold phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_MARKER;
		end else begin
			state_q <= state_d;
		end
	end

	// No byte is taken while a run expands
	a_run_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> in_stall)
		else $error("input accepted during run expansion");

	// The final run segment returns to literal decoding
	a_run_exit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.run_step && stat.run_last |=> state_q == ST_DATA)
		else $error("run did not return to data phase");

	// A terminator always leads to a new marker
	a_end_to_marker: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.end_stream |=> state_q == ST_MARKER)
		else $error("stream end did not restart at marker");

endmodule

// ===== hw/rtl/rptd_dp.sv =====
// ----------------------------------------------------------------------------
// rptd_dp
// Datapath: escape marker, run count and value, tile buffer with fill
// position, tile counter and the result register.
// ----------------------------------------------------------------------------
module rptd_dp
	import rptd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  in_byte,
	input  rptd_cmd_t   cmd,
	output rptd_stat_t  stat,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  tile_number,
	output logic [63:0] rows_upper,
	output logic [63:0] rows_lower,
	output logic        stream_done,
	output logic [3:0]  leftover_bytes,
	output logic        last_of_run
);

	logic [7:0]        marker_q;
	logic [7:0]        rem_q;
	logic [7:0]        value_q;
	logic [FILL_W-1:0] fill_q;
	logic [7:0]        tile_cnt_q;
	logic [7:0]        buf_q [TILE_BYTES];
	logic [7:0]        buf_d [TILE_BYTES];

	logic              out_valid_q;
	logic [7:0]        tile_number_q;
	logic [127:0]      pix_q;
	logic              done_q;
	logic [3:0]        left_q;
	logic              last_q;

	logic [SEG_W-1:0]  space;
	logic [SEG_W-1:0]  run_len;
	logic [SEG_W-1:0]  wr_len;
	logic [SEG_W-1:0]  fill_end;
	logic [7:0]        rem_next;
	logic [7:0]        wr_val;
	logic              wr_en;
	logic              tile_full;
	logic              emit_tile;
	logic              out_load;
	logic [127:0]      pix;

	// Segment of the run that fits the rest of the tile
	assign space    = SEG_W'(TILE_BYTES) - {1'b0, fill_q};
	assign run_len  = (rem_q < {{(8-SEG_W){1'b0}}, space}) ? rem_q[SEG_W-1:0] : space;
	assign rem_next = rem_q - {{(8-SEG_W){1'b0}}, run_len};
	assign wr_en    = cmd.push_lit || cmd.run_step;
	assign wr_val   = cmd.push_lit ? in_byte : value_q;
	assign wr_len   = cmd.push_lit ? SEG_W'(1) : run_len;
	assign fill_end = {1'b0, fill_q} + wr_len;
	assign tile_full = fill_end[SEG_W-1];
	assign emit_tile = wr_en && tile_full;
	assign out_load  = emit_tile || cmd.end_stream;

	// Status back to the controller
	assign stat.is_marker = (in_byte == marker_q);
	assign stat.byte_zero = (in_byte == 8'd0);
	assign stat.run_last  = (rem_q <= {{(8-SEG_W){1'b0}}, space});
	assign stat.out_free  = !out_valid_q || !out_stall;

	// Write the segment into the tile buffer
	always_comb begin
		for (int i = 0; i < TILE_BYTES; i++) begin
			if (wr_en && (SEG_W'(i) >= {1'b0, fill_q}) && (SEG_W'(i) < fill_end)) begin
				buf_d[i] = wr_val;
			end else begin
				buf_d[i] = buf_q[i];
			end
		end
	end

	assign pix = tile_pixels(buf_d);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < TILE_BYTES; i++) begin
				buf_q[i] <= buf_d[i];
			end
		end
	end

	// Marker, run state, fill position and tile counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q   <= '0;
			rem_q      <= '0;
			value_q    <= '0;
			fill_q     <= '0;
			tile_cnt_q <= '0;
		end else begin
			if (cmd.set_marker) begin
				marker_q <= in_byte;
			end
			if (cmd.load_count) begin
				rem_q <= in_byte;
			end else if (cmd.run_step) begin
				rem_q <= rem_next;
			end
			if (cmd.load_value) begin
				value_q <= in_byte;
			end
			if (cmd.end_stream) begin
				fill_q     <= '0;
				tile_cnt_q <= '0;
				rem_q      <= '0;
			end else if (wr_en) begin
				fill_q <= fill_end[FILL_W-1:0];
				if (tile_full) begin
					tile_cnt_q <= tile_cnt_q + 8'd1;
				end
			end
		end
	end

	// Result register: load a tile or the stream end, drop the beat once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load tile or stream-end fields; last tile of a run: rest cannot fill a tile
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (cmd.end_stream) begin
				tile_number_q <= '0;
				pix_q         <= '0;
				done_q        <= 1'b1;
				left_q        <= fill_q;
				last_q        <= 1'b1;
			end else begin
				tile_number_q <= tile_cnt_q;
				pix_q         <= pix;
				done_q        <= 1'b0;
				left_q        <= '0;
				last_q        <= cmd.push_lit || (rem_next < 8'(TILE_BYTES));
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign tile_number    = tile_number_q;
	assign rows_upper     = pix_q[63:0];
	assign rows_lower     = pix_q[127:64];
	assign stream_done    = done_q;
	assign leftover_bytes = left_q;
	assign last_of_run    = last_q;

	// Never overwrite a beat the receiver has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> stat.out_free)
		else $error("result register overwritten while stalled");

	// A stream end clears the fill position and tile counter
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.end_stream |=> fill_q == '0 && tile_cnt_q == '0)
		else $error("stream end left fill state behind");

	// A stream-end beat carries no tile
	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> pix_q == '0 && tile_number_q == '0 && last_q)
		else $error("stream-end beat carries tile data");

endmodule

// ===== hw/rtl/rle_planar_tile_decoder.sv =====
// ----------------------------------------------------------------------------
// rle_planar_tile_decoder
// Escape-byte run-length decoder that assembles 2-bit planar tiles.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (in_valid, in_stall, in_byte) carries one compressed byte
//   a beat. The first byte of a stream is the escape marker; then literals,
//   or marker + count + value runs; marker + zero count ends the stream.
// - Output channel (out_valid, out_stall, result fields) carries one beat per
//   full 16-byte tile (64 two-bit pixels) and one beat per stream end with
//   stream_done set and the count of dropped partial-tile bytes.
//   last_of_run marks the final beat caused by one input byte.
// - A result is loaded into the output register when the byte or run segment
//   that completes it is taken. After a value byte the run expands one tile
//   segment at a time (a segment ends at a tile boundary or at the end of
//   the run), during which in_stall is high.
// - Reset clears phase, marker, fill position and tile counter; the next
//   byte is taken as a marker. The tile buffer itself is not cleared.
// - While out_stall holds a beat, the decoder stops taking bytes and
//   stops expanding runs; nothing is lost.
// ----------------------------------------------------------------------------
module rle_planar_tile_decoder
	import rptd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  tile_number,
	output logic [63:0] rows_upper,
	output logic [63:0] rows_lower,
	output logic        stream_done,
	output logic [3:0]  leftover_bytes,
	output logic        last_of_run
);

	rptd_cmd_t  cmd;
	rptd_stat_t stat;

	// Phase sequencer
	rptd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Tile buffer and result register
	rptd_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_byte        (in_byte),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.tile_number    (tile_number),
		.rows_upper     (rows_upper),
		.rows_lower     (rows_lower),
		.stream_done    (stream_done),
		.leftover_bytes (leftover_bytes),
		.last_of_run    (last_of_run)
	);

endmodule

// ===== verif/rptd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rptd_checker
// Watches both channels of the run-length tile decoder, decodes every
// accepted byte with its own model of the escape-byte scheme, queues the
// tile and stream-end beats that must follow, and compares each output beat
// field by field against the oldest queued beat.
// ----------------------------------------------------------------------------
module rptd_checker
	import rptd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  tile_number,
	input  logic [63:0] rows_upper,
	input  logic [63:0] rows_lower,
	input  logic        stream_done,
	input  logic [3:0]  leftover_bytes,
	input  logic        last_of_run,
	output int          fails,
	output int          pending
);

	localparam int REPORT_CAP = 40;

	typedef enum logic [1:0] {
		WAIT_MARKER,
		TAKE_DATA,
		TAKE_COUNT,
		TAKE_VALUE
	} decode_phase_t;

	typedef struct packed {
		logic [7:0]  tile_number;
		logic [63:0] rows_upper;
		logic [63:0] rows_lower;
		logic        stream_done;
		logic [3:0]  leftover_bytes;
		logic        last_of_run;
	} tile_beat_t;

	decode_phase_t phase;
	logic [7:0]    marker;
	logic [7:0]    run_len;
	logic [7:0]    tile_buf [TILE_BYTES];
	logic [4:0]    fill;
	logic [7:0]    tile_idx;
	tile_beat_t    expected_tiles [$];
	int            mismatch_count;

	// Append one decoded byte; build the pixel words when the tile fills
	task automatic append_byte(input logic [7:0] b, ref tile_beat_t beats [$]);
		tile_beat_t t;
		logic [1:0] px;
		int         pos;
		tile_buf[fill[3:0]] = b;
		fill = fill + 5'd1;
		if (fill == TILE_BYTES) begin
			t = '0;
			t.tile_number = tile_idx;
			for (int y = 0; y < PLANE_BYTES; y++) begin
				for (int x = 0; x < ROW_PIXELS; x++) begin
					px  = {tile_buf[PLANE_BYTES + y][7 - x], tile_buf[y][7 - x]};
					pos = 2 * (ROW_PIXELS * (y % 4) + x);
					if (y < 4)
						t.rows_upper[pos +: 2] = px;
					else
						t.rows_lower[pos +: 2] = px;
				end
			end
			beats = {beats, t};
			tile_idx = tile_idx + 8'd1;
			fill = '0;
		end
	endtask

	// Advance the decoder by one compressed byte and queue its beats
	task automatic decode_byte(input logic [7:0] b);
		tile_beat_t beats [$];
		tile_beat_t t;
		case (phase)
			WAIT_MARKER: begin
				marker = b;
				phase  = TAKE_DATA;
			end
			TAKE_DATA: begin
				if (b == marker)
					phase = TAKE_COUNT;
				else
					append_byte(b, beats);
			end
			TAKE_COUNT: begin
				if (b == 8'd0) begin
					// Stream end: report the dropped partial tile, start over
					t = '0;
					t.stream_done    = 1'b1;
					t.leftover_bytes = fill[3:0];
					beats = {beats, t};
					fill     = '0;
					tile_idx = '0;
					run_len  = '0;
					phase    = WAIT_MARKER;
				end else begin
					run_len = b;
					phase   = TAKE_VALUE;
				end
			end
			TAKE_VALUE: begin
				repeat (run_len) append_byte(b, beats);
				run_len = '0;
				phase   = TAKE_DATA;
			end
		endcase
		if (beats.size() > 0)
			beats[beats.size() - 1].last_of_run = 1'b1;
		expected_tiles = {expected_tiles, beats};
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_CAP)
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name,
					want, got);
		end
	endtask

	// Compare output beats first, then decode the input beat of this edge
	always @(posedge clk or negedge arst_n) begin
		tile_beat_t want;
		if (!arst_n) begin
			phase          = WAIT_MARKER;
			marker         = '0;
			run_len        = '0;
			fill           = '0;
			tile_idx       = '0;
			mismatch_count = 0;
			expected_tiles.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_tiles.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_CAP)
						$display("%0t: beat with nothing expected, actual tile %0d done %b",
							$time, tile_number, stream_done);
				end else begin
					want = expected_tiles.pop_front();
					check_field("tile_number", 64'(want.tile_number), 64'(tile_number));
					check_field("rows_upper", want.rows_upper, rows_upper);
					check_field("rows_lower", want.rows_lower, rows_lower);
					check_field("stream_done", 64'(want.stream_done), 64'(stream_done));
					check_field("leftover_bytes", 64'(want.leftover_bytes),
						64'(leftover_bytes));
					check_field("last_of_run", 64'(want.last_of_run), 64'(last_of_run));
				end
			end
			if (in_valid && !in_stall)
				decode_byte(in_byte);
		end
		fails   <= mismatch_count;
		pending <= expected_tiles.size();
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives compressed byte streams into the run-length tile decoder: a short
// directed set of corner streams, one stream long enough to wrap the tile
// counter, then random streams of literals, runs and terminators with some
// broken sequences. Sender bursts and receiver stalls vary throughout; the
// checker predicts and compares every beat.
// ----------------------------------------------------------------------------
module testbench;

	localparam int BYTE_TARGET = 300;
	localparam int IDLE_LIMIT  = 2000;
	localparam int TAIL_CYCLES = 40;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  in_byte;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  tile_number;
	logic [63:0] rows_upper;
	logic [63:0] rows_lower;
	logic        stream_done;
	logic [3:0]  leftover_bytes;
	logic        last_of_run;
	int          fails;
	int          pending;

	int          burst_left = 0;
	int          sent_bytes = 0;
	int          idle_cycles = 0;
	int          stall_left = 0;
	int          stall_mode = 0;
	logic [7:0]  marker_now;

	rle_planar_tile_decoder u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.tile_number    (tile_number),
		.rows_upper     (rows_upper),
		.rows_lower     (rows_lower),
		.stream_done    (stream_done),
		.leftover_bytes (leftover_bytes),
		.last_of_run    (last_of_run)
	);

	rptd_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.tile_number    (tile_number),
		.rows_upper     (rows_upper),
		.rows_lower     (rows_lower),
		.stream_done    (stream_done),
		.leftover_bytes (leftover_bytes),
		.last_of_run    (last_of_run),
		.fails          (fails),
		.pending        (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Stall the output side in phases: free, sparse stalls, dense stalls
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(10, 60);
		end
		stall_left--;
		case (stall_mode)
			0:       out_stall <= 1'b0;
			1:       out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	// End the run if nothing moves on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
				$display("** rle_planar_tile_decoder: FAILED **");
				$finish;
			end
		end
	end

	// Offer one byte, with a random gap at each burst boundary; hold until taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		burst_left--;
		sent_bytes++;
	endtask

	task automatic send_run(input logic [7:0] count, input logic [7:0] value);
		send_byte(marker_now);
		send_byte(count);
		send_byte(value);
	endtask

	task automatic send_end();
		send_byte(marker_now);
		send_byte(8'd0);
	endtask

	// One random stream: marker, literals and runs, usually a terminator
	task automatic random_stream();
		int         tokens;
		logic [7:0] b;
		logic [7:0] count;
		case ($urandom_range(0, 5))
			0:       marker_now = 8'h00;
			1:       marker_now = 8'hFF;
			default: marker_now = 8'($urandom_range(0, 255));
		endcase
		send_byte(marker_now);
		tokens = $urandom_range(1, 20);
		repeat (tokens) begin
			if ($urandom_range(0, 9) < 6) begin
				b = 8'($urandom_range(0, 255));
				if (b == marker_now)
					b = ~marker_now;
				send_byte(b);
			end else begin
				case ($urandom_range(0, 9))
					0:       count = 8'($urandom_range(1, 255));
					1:       count = marker_now == 8'd0 ? 8'd1 : marker_now;
					default: count = 8'($urandom_range(1, 20));
				endcase
				b = ($urandom_range(0, 7) == 0) ? marker_now : 8'($urandom_range(0, 255));
				send_run(count, b);
			end
		end
		// Mostly close the stream; sometimes break off into noise instead
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
		end else begin
			send_end();
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_byte  = 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Count and value equal to the marker, extreme literals, a 16-tile run,
		// then a terminator that drops a partial tile
		marker_now = 8'hA5;
		send_byte(marker_now);
		send_run(8'hA5, 8'hA5);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_run(8'hFF, 8'h3C);
		send_end();

		// Zero marker, run filling exactly one tile, terminator with nothing left
		marker_now = 8'h00;
		send_byte(marker_now);
		send_run(8'd16, 8'h81);
		send_end();

		// Empty stream with an all-ones marker
		marker_now = 8'hFF;
		send_byte(marker_now);
		send_end();

		// Long stream of maximum runs: wrap the tile counter past 255
		marker_now = 8'($urandom_range(0, 255));
		send_byte(marker_now);
		repeat (17) send_run(8'hFF, 8'($urandom_range(0, 255)));
		send_end();

		while (sent_bytes < BYTE_TARGET)
			random_stream();

		// Drain: wait for every expected beat, then watch for strays
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("** rle_planar_tile_decoder: PASSED **");
		else
			$display("** rle_planar_tile_decoder: FAILED **");
		$finish;
	end

endmodule
